[hdl/interval_table_binary_search_unit_assert.svh]
// Assertion macros for the interval table binary search unit.
`ifndef INTERVAL_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define INTERVAL_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define ITBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define ITBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/itbs_pkg.sv]
// Shared types and constants for the interval table binary search unit.
`timescale 1ns / 1ps

package itbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = IDX_W + 1;
   localparam int DATA_W      = 32;
   localparam int QADDR_W     = 64;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] start;
      logic [DATA_W-1:0] length;
      logic [DATA_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } ram_cmd_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] payload;
   } result_type;

endpackage

[hdl/itbs_table_ram.sv]
// Entry table: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module itbs_table_ram (
   input  logic                  clock,
   input  itbs_pkg::ram_cmd_type cmd,
   output itbs_pkg::entry_type   rd_data
);

   itbs_pkg::entry_type mem_ff [itbs_pkg::TABLE_DEPTH];
   itbs_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/itbs_search_ctrl.sv]
// Search sequencer: takes items, writes loads, bisects the table for lookups.
`timescale 1ns / 1ps

module itbs_search_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [itbs_pkg::IDX_W-1:0]            req_entry_index,
   input  logic [itbs_pkg::DATA_W-1:0]           req_entry_start,
   input  logic [itbs_pkg::DATA_W-1:0]           req_entry_length,
   input  logic [itbs_pkg::DATA_W-1:0]           req_entry_payload,
   input  logic [itbs_pkg::QADDR_W-1:0]          req_query_addr,
   input  logic [itbs_pkg::COUNT_W-1:0]          entry_count,
   output itbs_pkg::ram_cmd_type                 ram_cmd,
   input  itbs_pkg::entry_type                   rd_data,
   output logic                                  res_valid,
   output itbs_pkg::result_type                  res,
   input  logic                                  res_take
);

   itbs_pkg::state_type                state_ff, state_in;
   logic [itbs_pkg::COUNT_W-1:0]       lo_ff, lo_in;
   logic [itbs_pkg::COUNT_W-1:0]       hi_ff, hi_in;
   logic [itbs_pkg::COUNT_W-1:0]       mid_ff, mid_in;
   logic [itbs_pkg::DATA_W-1:0]        addr_ff, addr_in;
   itbs_pkg::result_type               res_ff, res_in;

   logic                               accept;
   logic [itbs_pkg::COUNT_W-1:0]       count_clamped;
   logic [itbs_pkg::COUNT_W-1:0]       span;
   logic [itbs_pkg::COUNT_W-1:0]       mid_calc;
   logic [itbs_pkg::DATA_W-1:0]        end_addr;
   logic [itbs_pkg::COUNT_W-1:0]       lo_next;
   logic [itbs_pkg::COUNT_W-1:0]       hi_next;
   logic                               wide_addr;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != itbs_pkg::ST_IDLE);
   assign wide_addr = |req_query_addr[itbs_pkg::QADDR_W-1:itbs_pkg::DATA_W];

   assign count_clamped = (entry_count > itbs_pkg::COUNT_W'(itbs_pkg::TABLE_DEPTH))
                        ? itbs_pkg::COUNT_W'(itbs_pkg::TABLE_DEPTH) : entry_count;

   assign span     = hi_ff - lo_ff;
   assign mid_calc = lo_ff + (span >> 1);
   // end of interval wraps at 32 bits
   assign end_addr = rd_data.start + rd_data.length;

   always_comb begin
      ram_cmd.wr_en   = accept && (req_func == itbs_pkg::FUNC_LOAD)
                        && ({1'b0, req_entry_index} <
                            itbs_pkg::COUNT_W'(itbs_pkg::TABLE_DEPTH));
      ram_cmd.wr_addr = req_entry_index;
      ram_cmd.wr_data = '{start:   req_entry_start,
                          length:  req_entry_length,
                          payload: req_entry_payload};
      ram_cmd.rd_en   = (state_ff == itbs_pkg::ST_ISSUE);
      ram_cmd.rd_addr = mid_calc[itbs_pkg::IDX_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      addr_in  = addr_ff;
      res_in   = res_ff;
      lo_next  = lo_ff;
      hi_next  = hi_ff;
      unique case (state_ff)
         itbs_pkg::ST_IDLE: begin
            if (accept && (req_func == itbs_pkg::FUNC_LOOKUP)) begin
               addr_in = req_query_addr[itbs_pkg::DATA_W-1:0];
               lo_in   = '0;
               hi_in   = count_clamped;
               res_in  = '{hit: 1'b0, payload: '0};
               if (wide_addr || (count_clamped == '0)) begin
                  state_in = itbs_pkg::ST_HOLD;
               end else begin
                  state_in = itbs_pkg::ST_ISSUE;
               end
            end
         end
         itbs_pkg::ST_ISSUE: begin
            mid_in   = mid_calc;
            state_in = itbs_pkg::ST_CHECK;
         end
         itbs_pkg::ST_CHECK: begin
            if (addr_ff < rd_data.start) begin
               hi_next = mid_ff;
            end else begin
               lo_next = mid_ff + itbs_pkg::COUNT_W'(1);
            end
            if ((addr_ff >= rd_data.start) && (addr_ff < end_addr)) begin
               res_in   = '{hit: 1'b1, payload: rd_data.payload};
               state_in = itbs_pkg::ST_HOLD;
            end else if (hi_next > lo_next) begin
               lo_in    = lo_next;
               hi_in    = hi_next;
               state_in = itbs_pkg::ST_ISSUE;
            end else begin
               state_in = itbs_pkg::ST_HOLD;
            end
         end
         itbs_pkg::ST_HOLD: begin
            if (res_take) begin
               state_in = itbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itbs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
   end

   assign res_valid = (state_ff == itbs_pkg::ST_HOLD);
   assign res       = res_ff;

endmodule

[hdl/interval_table_binary_search_unit.sv]
// Lookup: each probe is a RAM read (ISSUE), then a compare (CHECK), up to 11 probes
// at 1024 entries; the result then waits in HOLD until the output register takes it.
// Wide address or empty table: miss result with no probe. Load: written, no result.
// One lookup at a time; next item taken once the result is in the output register.
// Reset clears the sequencer, output valid flag and entry_count; table contents
// stay undefined until loaded.
`timescale 1ns / 1ps

module interval_table_binary_search_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [itbs_pkg::IDX_W-1:0]            req_entry_index,
   input  logic [itbs_pkg::DATA_W-1:0]           req_entry_start,
   input  logic [itbs_pkg::DATA_W-1:0]           req_entry_length,
   input  logic [itbs_pkg::DATA_W-1:0]           req_entry_payload,
   input  logic [itbs_pkg::QADDR_W-1:0]          req_query_addr,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic [itbs_pkg::DATA_W-1:0]           rsp_payload_out,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [itbs_pkg::COUNT_W-1:0]          csr_entry_count
);

   logic [itbs_pkg::COUNT_W-1:0] entry_count_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   itbs_pkg::result_type         rsp_ff;
   itbs_pkg::ram_cmd_type        ram_cmd;
   itbs_pkg::entry_type          rd_data;
   logic                         res_valid;
   itbs_pkg::result_type         res;
   logic                         res_take;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         entry_count_ff <= csr_entry_count;
      end
   end

   itbs_table_ram u_table_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (rd_data)
   );

   itbs_search_ctrl u_search_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_entry_index   (req_entry_index),
      .req_entry_start   (req_entry_start),
      .req_entry_length  (req_entry_length),
      .req_entry_payload (req_entry_payload),
      .req_query_addr    (req_query_addr),
      .entry_count       (entry_count_ff),
      .ram_cmd           (ram_cmd),
      .rd_data           (rd_data),
      .res_valid         (res_valid),
      .res               (res),
      .res_take          (res_take)
   );

   // output register takes a result when empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_ff.hit;
   assign rsp_payload_out = rsp_ff.payload;

endmodule

[hdl/itbs_checker.sv]
// Port-level checks for the interval table binary search unit, bound to the top.
`timescale 1ns / 1ps
`include "interval_table_binary_search_unit_assert.svh"

module itbs_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_func,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  rsp_hit,
   input  logic [itbs_pkg::DATA_W-1:0]           rsp_payload_out
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // a held item keeps its result
   `ITBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_hit) && $stable(rsp_payload_out), "rsp item changed while stalled")

   `ITBS_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_hit,
      rsp_payload_out == '0, "miss with non-zero payload")

   // a load leaves the sequencer idle
   `ITBS_ASSERT_NEXT(a_load_single, req_acc && (req_func == itbs_pkg::FUNC_LOAD),
      !req_stall, "busy after a load item")

   `ITBS_ASSERT_NEXT(a_lookup_busy, req_acc && (req_func == itbs_pkg::FUNC_LOOKUP),
      req_stall, "lookup item did not occupy the search")

endmodule

bind interval_table_binary_search_unit itbs_checker u_itbs_checker (.*);

[bench/interval_table_binary_search_unit_checker.sv]
// Checker for the interval table search unit: mirrors the table, predicts lookups, compares.
`timescale 1ns / 1ps

module interval_table_binary_search_unit_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_func,
   input  logic [itbs_pkg::IDX_W-1:0]    req_entry_index,
   input  logic [itbs_pkg::DATA_W-1:0]   req_entry_start,
   input  logic [itbs_pkg::DATA_W-1:0]   req_entry_length,
   input  logic [itbs_pkg::DATA_W-1:0]   req_entry_payload,
   input  logic [itbs_pkg::QADDR_W-1:0]  req_query_addr,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,
   input  logic [itbs_pkg::DATA_W-1:0]   rsp_payload_out,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [itbs_pkg::COUNT_W-1:0]  csr_entry_count,
   output int unsigned                   outstanding,
   output int unsigned                   failures,
   output int unsigned                   hits_seen
);
   import itbs_pkg::*;

   logic [DATA_W-1:0]  start_mem   [TABLE_DEPTH];
   logic [DATA_W-1:0]  length_mem  [TABLE_DEPTH];
   logic [DATA_W-1:0]  payload_mem [TABLE_DEPTH];
   logic [COUNT_W-1:0] entry_count;
   result_type         expected_answers [$];
   result_type         want;
   int unsigned        fail_total;
   int unsigned        result_index;
   int unsigned        hit_total;

   assign failures  = fail_total;
   assign hits_seen = hit_total;

   initial begin
      fail_total   = 0;
      result_index = 0;
      hit_total    = 0;
      entry_count  = '0;
      outstanding  = 0;
   end

   // bisection over the live part of the table; end of range wraps at 32 bits
   function automatic result_type find_covering_entry(input logic [QADDR_W-1:0] addr);
      result_type        ans;
      int                lo;
      int                hi;
      int                mid;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] e;
      ans.hit     = 1'b0;
      ans.payload = '0;
      lo = 0;
      hi = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
      if (addr[QADDR_W-1:DATA_W] != '0) return ans;
      a = addr[DATA_W-1:0];
      while (hi > lo) begin
         mid = lo + (hi - lo) / 2;
         s   = start_mem[mid];
         e   = s + length_mem[mid];
         if (a < s) begin
            hi = mid;
         end else if (a < e) begin
            ans.hit     = 1'b1;
            ans.payload = payload_mem[mid];
            return ans;
         end else begin
            lo = mid + 1;
         end
      end
      return ans;
   endfunction

   task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                                input logic [DATA_W-1:0] got_v);
      fail_total++;
      if (fail_total <= 10)
         $display("%0t ns, result %0d: %s expected %h, got %h",
                  $realtime, result_index, what, want_v, got_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entry_count = '0;
         expected_answers.delete();
      end else begin
         if (csr_valid && csr_ready)
            entry_count = csr_entry_count;
         if (req_valid && !req_stall) begin
            if (req_func == FUNC_LOAD) begin
               start_mem[req_entry_index]   = req_entry_start;
               length_mem[req_entry_index]  = req_entry_length;
               payload_mem[req_entry_index] = req_entry_payload;
            end else begin
               expected_answers.push_back(find_covering_entry(req_query_addr));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            result_index++;
            if (rsp_hit === 1'b1)
               hit_total++;
            if (expected_answers.size() == 0) begin
               flag_mismatch("unexpected item, payload", '0, rsp_payload_out);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_hit !== want.hit)
                  flag_mismatch("hit", DATA_W'(want.hit), DATA_W'(rsp_hit));
               if (rsp_payload_out !== want.payload)
                  flag_mismatch("payload_out", want.payload, rsp_payload_out);
            end
         end
      end
      outstanding <= expected_answers.size();
   end

endmodule

[bench/interval_table_binary_search_unit_test.sv]
// Testbench top for the interval table search unit: stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module interval_table_binary_search_unit_test;
   import itbs_pkg::*;

   localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
   localparam int SETTLE      = 32;
   localparam int ITEM_TARGET = 1300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = FUNC_LOAD;
   logic [IDX_W-1:0]     req_entry_index = '0;
   logic [DATA_W-1:0]    req_entry_start = '0;
   logic [DATA_W-1:0]    req_entry_length = '0;
   logic [DATA_W-1:0]    req_entry_payload = '0;
   logic [QADDR_W-1:0]   req_query_addr = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_hit;
   logic [DATA_W-1:0]    rsp_payload_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_entry_count = '0;

   int unsigned          outstanding;
   int unsigned          failures;
   int unsigned          hits_seen;

   // stimulus-side copy of the table, used to aim lookups at entries and to keep starts on rewrites
   logic [DATA_W-1:0]    table_start  [TABLE_DEPTH];
   logic [DATA_W-1:0]    table_length [TABLE_DEPTH];
   int                   searched = 0;
   bit                   steady_sender = 1'b0;
   bit                   full_loaded = 1'b0;
   int unsigned          lookups_sent = 0;
   int unsigned          loads_sent = 0;
   int unsigned          settings_written = 0;
   int unsigned          stall_run = 0;
   int                   stall_pick;

   always #4 clock = ~clock;

   interval_table_binary_search_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_entry_index(req_entry_index), .req_entry_start(req_entry_start),
      .req_entry_length(req_entry_length), .req_entry_payload(req_entry_payload),
      .req_query_addr(req_query_addr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_payload_out(rsp_payload_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_entry_count(csr_entry_count)
   );

   interval_table_binary_search_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_entry_index(req_entry_index), .req_entry_start(req_entry_start),
      .req_entry_length(req_entry_length), .req_entry_payload(req_entry_payload),
      .req_query_addr(req_query_addr),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_hit(rsp_hit),
      .rsp_payload_out(rsp_payload_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_entry_count(csr_entry_count),
      .outstanding(outstanding), .failures(failures), .hits_seen(hits_seen)
   );

   // result-side back-pressure: short bursts mostly, the odd long stall, quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run <= 0;
      end else if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 10) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(100, 300);
         end else if (stall_pick < 45) begin
            rsp_stall <= 1'b0;
            stall_run <= $urandom_range(0, 5);
         end else if (stall_pick < 90) begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_run <= $urandom_range(8, 40);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   // called at a rising edge; returns at the edge where the item is taken
   task automatic send_item(input logic func, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] l,
                            input logic [DATA_W-1:0] p, input logic [QADDR_W-1:0] qa);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_entry_index   <= idx;
      req_entry_start   <= s;
      req_entry_length  <= l;
      req_entry_payload <= p;
      req_query_addr    <= qa;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_entry(input int idx, input logic [DATA_W-1:0] s,
                             input logic [DATA_W-1:0] l, input logic [DATA_W-1:0] p);
      send_item(FUNC_LOAD, IDX_W'(idx), s, l, p, {$urandom, $urandom});
      table_start[idx]  = s;
      table_length[idx] = l;
      loads_sent++;
   endtask

   task automatic look_up(input logic [QADDR_W-1:0] addr);
      send_item(FUNC_LOOKUP, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                $urandom, $urandom, $urandom, addr);
      lookups_sent++;
   endtask

   // only once all lookups are answered and any load has settled
   task automatic set_entry_count(input int value);
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_entry_count <= COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      searched = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
      settings_written++;
   endtask

   // sorted tables keep every start below 2^32; the last length may wrap
   task automatic fill_table(input int n, input bit ordered);
      logic [63:0]       span;
      logic [63:0]       cursor;
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] l;
      span   = 64'h1_0000_0000 / 64'(n + 1);
      cursor = 64'($urandom_range(0, 32'(span - 64'd1)));
      for (int i = 0; i < n; i++) begin
         if (ordered) begin
            s = DATA_W'(cursor) + $urandom_range(0, 32'(span / 64'd2));
            l = ($urandom_range(0, 19) == 0) ? '0 : $urandom_range(1, 32'(span / 64'd2));
            if (i == n - 1 && $urandom_range(0, 9) == 0)
               l = $urandom;
            cursor = 64'(s) + 64'(l);
         end else begin
            s = $urandom;
            l = $urandom;
         end
         load_entry(i, s, l, $urandom);
      end
   endtask

   function automatic logic [QADDR_W-1:0] pick_query(input int n);
      int                k;
      int                r;
      logic [DATA_W-1:0] s;
      logic [DATA_W-1:0] l;
      logic [DATA_W-1:0] upper;
      r = $urandom_range(0, 99);
      if (n > 0 && r < 55) begin
         k = $urandom_range(0, n - 1);
         s = table_start[k];
         l = table_length[k];
         case ($urandom_range(0, 4))
            0: return {32'h0, s};
            1: return {32'h0, s + l - 32'd1};
            2: return {32'h0, s + l};
            3: return {32'h0, s - 32'd1};
            default: begin
               if (l == 0) return {32'h0, s};
               return {32'h0, s + $urandom_range(0, l - 1)};
            end
         endcase
      end else if (r < 70) begin
         return {32'h0, $urandom};
      end else if (r < 82) begin
         upper = $urandom;
         if (upper == 0) upper = 32'd1;
         return {upper, $urandom};
      end else if (r < 88) begin
         return '0;
      end else if (r < 94) begin
         return 64'h0000_0000_FFFF_FFFF;
      end else if (r < 97) begin
         return 64'h0000_0001_0000_0000;
      end
      return '1;
   endfunction

   initial begin
      int phase;
      int n;
      int r;
      int k;
      int count_value;
      int steps;
      phase = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table: everything misses
      set_entry_count(0);
      look_up(64'h0);
      look_up(64'h0000_0000_FFFF_FFFF);
      look_up('1);

      // small hand-made table: zero length, full-range payloads, wrapping end
      load_entry(0, 32'h0000_0000, 32'h0000_0010, 32'hFFFF_FFFF);
      load_entry(1, 32'h0000_0100, 32'h0000_0000, 32'h0000_0001);
      load_entry(2, 32'h0000_0200, 32'h0000_0100, 32'hA5A5_5A5A);
      load_entry(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      load_entry(4, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h0000_1234);
      load_entry(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0007);
      set_entry_count(5);
      look_up(64'h0);
      look_up(64'hF);
      look_up(64'h10);
      look_up(64'h100);
      look_up(64'h2FF);
      look_up(64'h300);
      look_up(64'h8000_0000);
      look_up(64'hFFFF_FFFE);
      look_up(64'hFFFF_FFFF);
      look_up(64'h1_0000_0000);
      look_up('1);
      lookups_sent = 0;

      // the one full-table fill dominates the item count
      while (loads_sent + lookups_sent < ITEM_TARGET) begin
         steady_sender = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (phase == 1) begin
            fill_table(TABLE_DEPTH, 1'b1);
            full_loaded = 1'b1;
            count_value = TABLE_DEPTH;
         end else if (phase == 2) begin
            count_value = COUNT_MAX;
         end else if (full_loaded && r < 8) begin
            count_value = $urandom_range(TABLE_DEPTH + 1, COUNT_MAX);
         end else begin
            n = (r < 20) ? 1 : $urandom_range(2, 40);
            fill_table(n, $urandom_range(0, 9) != 0);
            count_value = n;
         end
         set_entry_count(count_value);
         steps = $urandom_range(10, 60);
         repeat (steps) begin
            if ($urandom_range(0, 99) < 8) begin
               // rewrite a slot mid-run; keeping the start leaves the order mostly intact
               if (searched > 0 && $urandom_range(0, 3) != 0) begin
                  k = $urandom_range(0, searched - 1);
                  load_entry(k, table_start[k], $urandom_range(0, 4096), $urandom);
               end else begin
                  load_entry($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom, $urandom);
               end
            end else begin
               look_up(pick_query(searched));
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);

      $display("Covered %0d random lookups (%0d hits seen) and %0d table loads", lookups_sent,
               hits_seen, loads_sent);
      $display("across %0d entry count settings from 0 to %0d; %0d mismatches", settings_written,
               COUNT_MAX, failures);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/itbs_pkg.sv
hdl/itbs_table_ram.sv
hdl/itbs_search_ctrl.sv
hdl/interval_table_binary_search_unit.sv
hdl/itbs_checker.sv
bench/interval_table_binary_search_unit_checker.sv
bench/interval_table_binary_search_unit_test.sv
